>>> sv/aebd_pkg.sv
// Shared types and constants for the audio energy beat detector.
// No dependencies; imported by every module of the block.
package aebd_pkg;

  localparam int E_W   = 12;  // frame energy, up to 64 bars of 63
  localparam int N_W   = 7;   // bar count, up to 64
  localparam int AVG_W = 20;  // running average, 8 fraction bits
  localparam int BEAT_W = 16; // beat level, Q0.16
  localparam int PH_W  = 32;  // phase, Q16.16
  localparam int POS_W = 32;

  localparam int PROD_W = 36;
  localparam int ACC_W  = 37;
  localparam int DEN_W  = 22;
  localparam int D_W    = 8;
  localparam int T_W    = 13;

  localparam int DIV_NW = 40;
  localparam int DIV_DW = 24;
  localparam int DIV_CW = $clog2(DIV_NW);

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 88;

  localparam logic [15:0] AVG_OLD_W    = 16'd60293;
  localparam logic [15:0] AVG_NEW_W    = 16'd5243;
  localparam logic [15:0] SMOOTH_OLD_W = 16'd36045;
  localparam logic [15:0] SMOOTH_NEW_W = 16'd29491;
  localparam logic [15:0] PHASE_DEN    = 16'd50000;
  localparam logic [15:0] ROUND_HALF   = 16'd32768;
  localparam logic [AVG_W-1:0]  AVG_ONE  = 20'd256;
  localparam logic [AVG_W-1:0]  AVG_MAX  = 20'hFFFFF;
  localparam logic [BEAT_W-1:0] BEAT_MAX = 16'd40960;
  localparam logic [D_W-1:0]    SEEK_CLAMP = 8'd200;
  localparam logic [PH_W-1:0]   DRIFT_PLAY = 32'd1311;
  localparam logic [PH_W-1:0]   DRIFT_IDLE = 32'd262;

  typedef struct packed {
    logic [POS_W-1:0] position_ms;
    logic             is_playing;
    logic [N_W-1:0]   n;
    logic [E_W-1:0]   e;
  } frame_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AVG_MUL,
    S_AVG_SUM,
    S_AVG_WR,
    S_BEAT_SETUP,
    S_BEAT_DIV,
    S_SMOOTH_MUL,
    S_SMOOTH_SUM,
    S_PHASE_SETUP,
    S_PHASE_MUL,
    S_PHASE_DIV_START,
    S_PHASE_DIV,
    S_FINISH
  } back_state_t;

endpackage

>>> sv/aebd_front.sv
// Front end: accepts bars, sums the first MAX_BARS of a frame, queues a
// frame record on the last bar. Depends on aebd_pkg.
module aebd_front import aebd_pkg::*; #(
  parameter int MAX_BARS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_TDATA_W-1:0] s_tdata,
  input  logic                  s_tlast,
  input  logic                  q_full,
  output logic                  q_push,
  output frame_t                q_data
);

  logic [E_W-1:0] energy;
  logic [N_W-1:0] bar_count;
  logic [E_W-1:0] energy_next;
  logic [N_W-1:0] bar_count_next;
  logic           accept;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign q_push   = accept && s_tlast;

  always_comb begin
    energy_next    = energy;
    bar_count_next = bar_count;
    if (bar_count < N_W'(MAX_BARS)) begin
      energy_next    = energy + E_W'(s_tdata[5:0]);
      bar_count_next = bar_count + N_W'(1);
    end
    q_data.e           = energy_next;
    q_data.n           = bar_count_next;
    q_data.is_playing  = s_tdata[6];
    q_data.position_ms = s_tdata[38:7];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      energy    <= '0;
      bar_count <= '0;
    end else if (accept) begin
      if (s_tlast) begin
        energy    <= '0;
        bar_count <= '0;
      end else begin
        energy    <= energy_next;
        bar_count <= bar_count_next;
      end
    end
  end

endmodule

>>> sv/aebd_fifo.sv
// Short frame queue between front and back end.
// Depends on aebd_pkg for frame_t and depth.
module aebd_fifo import aebd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  frame_t push_data,
  output logic   full,
  input  logic   pop,
  output frame_t pop_data,
  output logic   empty
);

  frame_t             mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr;
  logic [FIFO_AW-1:0] rptr;
  logic [FIFO_AW:0]   count;

  assign full     = count == (FIFO_AW+1)'(FIFO_DEPTH);
  assign empty    = count == '0;
  assign pop_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wptr + FIFO_AW'(1);
      end
      if (pop) begin
        rptr <= (rptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rptr + FIFO_AW'(1);
      end
      if (push && !pop) begin
        count <= count + (FIFO_AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (FIFO_AW+1)'(1);
      end
    end
  end

endmodule

>>> sv/aebd_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on aebd_pkg for operand widths.
module aebd_div import aebd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic              busy,
  output logic [DIV_NW-1:0] quo
);

  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] divisor;
  logic [DIV_CW-1:0] cnt;
  logic [DIV_DW:0]   trial;
  logic              fits;

  assign trial = {rem, quo[DIV_NW-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (start) begin
      quo     <= num;
      rem     <= '0;
      divisor <= den;
    end else if (busy) begin
      quo <= {quo[DIV_NW-2:0], fits};
      rem <= fits ? DIV_DW'(trial - {1'b0, divisor}) : trial[DIV_DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CW'(DIV_NW - 1);
    end else if (busy) begin
      cnt <= cnt - DIV_CW'(1);
      if (cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

>>> sv/aebd_back.sv
// Back end: per-frame average, beat and phase update, output register.
// Depends on aebd_pkg; drives the shared divider aebd_div.
module aebd_back import aebd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_empty,
  input  frame_t                 q_data,
  output logic                   q_pop,
  output logic                   div_start,
  output logic [DIV_NW-1:0]      div_num,
  output logic [DIV_DW-1:0]      div_den,
  input  logic                   div_busy,
  input  logic [DIV_NW-1:0]      div_quo,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  back_state_t state;
  back_state_t state_next;

  logic [E_W-1:0]          e_r;
  logic [N_W-1:0]          n_r;
  logic                    play_r;
  logic signed [POS_W-1:0] pos_r;
  logic [AVG_W-1:0]        avg;
  logic [BEAT_W-1:0]       beat;
  logic [PH_W-1:0]         phase;
  logic signed [POS_W-1:0] prev;
  logic [PROD_W-1:0]       prod;
  logic [ACC_W-1:0]        acc;
  logic [BEAT_W-1:0]       raw;
  logic [PH_W-1:0]         inc;
  logic [D_W-1:0]          d;
  logic [T_W-1:0]          t;
  logic [DEN_W-1:0]        den_r;

  logic [AVG_W:0]    avg_sum;
  logic [AVG_W-1:0]  avg_new;
  logic [AVG_W-1:0]  scaled;
  logic              beat_go;
  logic [AVG_W-1:0]  diff;
  logic              step;
  logic [POS_W-1:0]  pos_diff;
  logic              out_load;
  logic [PH_W-1:0]   phase_new;

  always_comb begin
    avg_sum   = acc[ACC_W-1:16];
    avg_new   = (avg_sum > {1'b0, AVG_MAX}) ? AVG_MAX : avg_sum[AVG_W-1:0];
    scaled    = {e_r, 8'b0};
    beat_go   = (avg > AVG_ONE) && (scaled > avg);
    diff      = scaled - avg;
    step      = !pos_r[POS_W-1] && !prev[POS_W-1] && (pos_r >= prev);
    pos_diff  = POS_W'(pos_r - prev);
    phase_new = phase + inc + (play_r ? DRIFT_PLAY : DRIFT_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = S_AVG_MUL;
        end
      end
      S_AVG_MUL:  state_next = S_AVG_SUM;
      S_AVG_SUM:  state_next = S_AVG_WR;
      S_AVG_WR:   state_next = S_BEAT_SETUP;
      S_BEAT_SETUP: begin
        if (beat_go) begin
          div_start  = 1'b1;
          div_num    = DIV_NW'({DIV_NW'(diff) + DIV_NW'({diff, 1'b0}), 16'b0});
          div_den    = DIV_DW'(avg) + DIV_DW'({avg, 2'b0});
          state_next = S_BEAT_DIV;
        end else begin
          state_next = S_SMOOTH_MUL;
        end
      end
      S_BEAT_DIV: begin
        if (!div_busy) begin
          state_next = S_SMOOTH_MUL;
        end
      end
      S_SMOOTH_MUL: state_next = S_SMOOTH_SUM;
      S_SMOOTH_SUM: state_next = S_PHASE_SETUP;
      S_PHASE_SETUP: state_next = step ? S_PHASE_MUL : S_FINISH;
      S_PHASE_MUL:   state_next = S_PHASE_DIV_START;
      S_PHASE_DIV_START: begin
        div_start  = 1'b1;
        div_num    = DIV_NW'({prod[20:0], 16'b0}) + DIV_NW'(den_r >> 1);
        div_den    = DIV_DW'(den_r);
        state_next = S_PHASE_DIV;
      end
      S_PHASE_DIV: begin
        if (!div_busy) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        e_r    <= q_data.e;
        n_r    <= q_data.n;
        play_r <= q_data.is_playing;
        pos_r  <= $signed(q_data.position_ms);
      end
      S_AVG_MUL: prod <= PROD_W'(avg) * PROD_W'(AVG_OLD_W);
      S_AVG_SUM: begin
        acc <= ACC_W'(prod) + ((ACC_W'(e_r) * ACC_W'(AVG_NEW_W)) << 8)
             + ACC_W'(ROUND_HALF);
      end
      S_BEAT_SETUP: raw <= '0;
      S_BEAT_DIV: begin
        if (!div_busy) begin
          raw <= (div_quo > DIV_NW'(BEAT_MAX)) ? BEAT_MAX : div_quo[BEAT_W-1:0];
        end
      end
      S_SMOOTH_MUL: prod <= PROD_W'(beat) * PROD_W'(SMOOTH_OLD_W);
      S_SMOOTH_SUM: begin
        acc <= ACC_W'(prod) + ACC_W'(raw) * ACC_W'(SMOOTH_NEW_W) + ACC_W'(ROUND_HALF);
      end
      S_PHASE_SETUP: begin
        inc <= '0;
        d   <= (pos_diff > POS_W'(SEEK_CLAMP)) ? SEEK_CLAMP : pos_diff[D_W-1:0];
        t   <= T_W'({n_r, 5'b0}) + T_W'({n_r, 3'b0}) + T_W'(e_r);
      end
      S_PHASE_MUL: begin
        prod  <= PROD_W'(d) * PROD_W'(t);
        den_r <= DEN_W'(n_r) * DEN_W'(PHASE_DEN);
      end
      S_PHASE_DIV: begin
        if (!div_busy) begin
          inc <= div_quo[PH_W-1:0];
        end
      end
      S_FINISH: begin
        if (out_load) begin
          m_tdata <= {4'b0, n_r[5:0], phase_new, beat, avg[18:0], e_r[10:0]};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avg      <= AVG_ONE;
      beat     <= '0;
      phase    <= '0;
      prev     <= -32'sd1;
      m_tvalid <= 1'b0;
    end else begin
      if (state == S_AVG_WR) begin
        avg <= avg_new;
      end
      if (state == S_PHASE_SETUP) begin
        beat <= BEAT_W'(acc >> 16);
      end
      if (out_load) begin
        phase    <= phase_new;
        prev     <= pos_r;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

>>> sv/audio_energy_beat_detector_top.sv
// Top level of the audio energy beat detector.
// Depends on aebd_pkg, aebd_front, aebd_fifo, aebd_div, aebd_back.
//
//  channel   signals                    word
//  s_*       s_tvalid s_tready s_tlast  one spectrum bar, tlast = last bar of frame
//  m_*       m_tvalid m_tready          one result per frame
//
// A bar is taken every cycle while the frame queue (2 frames) has room.
// The back end takes one frame at a time; the beat division and the phase
// step, when needed, run on the shared divider. Frames that arrive faster
// than the back end finishes them fill the queue and stall s_tready.
// A finished result sits in the output register; the next frame is popped
// as soon as it is loaded. Reset is synchronous, no clearing pass.
module audio_energy_beat_detector_top import aebd_pkg::*; #(
  parameter int MAX_BARS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // [5:0] bar_level, [6] is_playing, [38:7] position_ms
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   s_tlast,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [10:0] frame_energy, [29:11] average_energy, [45:30] beat_pulse,
  // [77:46] anim_phase, [83:78] bars_counted
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  frame_t            push_data;
  frame_t            pop_data;
  logic              push;
  logic              pop;
  logic              full;
  logic              empty;
  logic              div_start;
  logic [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0] div_den;
  logic              div_busy;
  logic [DIV_NW-1:0] div_quo;

  aebd_front #(
    .MAX_BARS(MAX_BARS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .q_full  (full),
    .q_push  (push),
    .q_data  (push_data)
  );

  aebd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (full),
    .pop      (pop),
    .pop_data (pop_data),
    .empty    (empty)
  );

  aebd_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .busy (div_busy),
    .quo  (div_quo)
  );

  aebd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (empty),
    .q_data   (pop_data),
    .q_pop    (pop),
    .div_start(div_start),
    .div_num  (div_num),
    .div_den  (div_den),
    .div_busy (div_busy),
    .div_quo  (div_quo),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

>>> bench/tb_audio_energy_beat_detector_top.sv
// Self-checking bench for audio_energy_beat_detector_top: a table of directed frames
// followed by random frames, each result compared with the frame model or a typed want.
// Depends on aebd_pkg and the detector RTL only.
module tb_audio_energy_beat_detector_top import aebd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     BAR_LIMIT   = 32;
  localparam int     STALL_LIMIT = 4000;
  localparam longint AVG_OLD     = 60293;
  localparam longint AVG_NEW     = 5243;
  localparam longint BEAT_GAIN   = 196608;
  localparam longint BEAT_CAP    = 40960;
  localparam longint SMOOTH_OLD  = 36045;
  localparam longint SMOOTH_NEW  = 29491;
  localparam longint SEEK_MAX    = 200;
  localparam longint PHASE_SCALE = 50000;
  localparam longint DRIFT_ON    = 1311;
  localparam longint DRIFT_OFF   = 262;
  localparam longint POS_MAX     = 64'd2147483647;

  typedef struct packed {
    logic [10:0] energy;
    logic [18:0] avg;
    logic [15:0] pulse;
    logic [31:0] phase;
    logic [5:0]  bars;
  } frame_result_t;

  typedef struct packed {
    int                 nbars;
    logic [5:0]         level;
    logic               playing;
    logic signed [31:0] pos;
    logic               typed;
    frame_result_t      want;
  } frame_plan_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   s_tlast;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;

  audio_energy_beat_detector_top #(.MAX_BARS(BAR_LIMIT)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // frame model state
  logic [10:0]        acc_energy;
  logic [5:0]         acc_bars;
  logic [19:0]        run_avg;
  logic [15:0]        beat_lvl;
  logic [31:0]        phase;
  logic signed [31:0] last_pos;

  frame_result_t pending_frames[$];
  int            errors = 0;
  int            frames_seen = 0;
  int            rand_items = 0;
  int            idle_cycles = 0;
  bit            steady = 1'b0;
  bit            held_off = 1'b0;
  longint        stim_pos = -1;

  frame_plan_t directed_frames [9] = '{
    '{1,  6'd0,  1'b0, -32'sd1, 1'b1, '{11'd0, 19'd236, 16'd0, 32'd262, 6'd1}},
    '{1,  6'd63, 1'b1, 32'sd0, 1'b0, '0},            // first loud frame, beat clamps
    '{33, 6'd63, 1'b1, 32'sd0, 1'b0, '0},            // extra bar, same position
    '{2,  6'd0,  1'b0, 32'sd150, 1'b0, '0},          // silent frame, forward step
    '{3,  6'd63, 1'b1, 32'sd100, 1'b0, '0},          // position went backwards
    '{2,  6'd63, 1'b1, 32'sd2147483647, 1'b0, '0},   // seek clamp
    '{1,  6'd0,  1'b0, -32'sd1, 1'b0, '0},           // unknown position
    '{2,  6'd63, 1'b1, 32'sd10, 1'b0, '0},           // previous unknown
    '{2,  6'd21, 1'b0, 32'sd210, 1'b0, '0}           // step of exactly the clamp
  };

  function automatic bit track_bar(input logic [5:0] bar, input logic last,
                                   input logic playing, input logic signed [31:0] pos,
                                   output frame_result_t r);
    longint e, n, a, raw, scaled, d, nn, den, p, lp, inc;
    r = '0;
    if (acc_bars < BAR_LIMIT) begin
      acc_energy = acc_energy + bar;
      acc_bars   = acc_bars + 1;
    end
    if (!last) return 1'b0;
    e = acc_energy;
    n = acc_bars;
    p = pos;
    lp = last_pos;
    a = (longint'(run_avg) * AVG_OLD + e * 256 * AVG_NEW + 32768) >> 16;
    if (a > 64'hFFFFF) a = 64'hFFFFF;
    run_avg = a[19:0];
    raw = 0;
    scaled = e * 256;
    if (a > 256 && scaled > a) begin
      raw = (scaled - a) * BEAT_GAIN / (5 * a);
      if (raw > BEAT_CAP) raw = BEAT_CAP;
    end
    beat_lvl = 16'((longint'(beat_lvl) * SMOOTH_OLD + raw * SMOOTH_NEW + 32768) >> 16);
    if (p >= 0 && lp >= 0 && p >= lp) begin
      d = p - lp;
      if (d > SEEK_MAX) d = SEEK_MAX;
      nn = (n != 0) ? n : 1;
      den = PHASE_SCALE * nn;
      inc = (d * 65536 * (40 * nn + e) + den / 2) / den;
      phase = phase + inc[31:0];
    end
    phase = phase + (playing ? DRIFT_ON[31:0] : DRIFT_OFF[31:0]);
    last_pos = pos;
    r.energy = e[10:0];
    r.avg    = run_avg[18:0];
    r.pulse  = beat_lvl;
    r.phase  = phase;
    r.bars   = n[5:0];
    acc_energy = '0;
    acc_bars   = '0;
    return 1'b1;
  endfunction

  task automatic send_bar(input logic [5:0] bar, input logic last, input logic playing,
                          input logic signed [31:0] pos, input logic typed,
                          input frame_result_t want);
    frame_result_t r;
    while (!steady && $urandom_range(99) < 24) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tlast  <= last;
    s_tdata  <= {1'b0, pos, playing, bar};
    do @(posedge clk); while (!s_tready);
    if (track_bar(bar, last, playing, pos, r))
      pending_frames.push_back(typed ? want : r);
    @(negedge clk);
  endtask

  task automatic send_frame(input int nbars, input int lo, input int hi,
                            input logic playing, input logic signed [31:0] pos,
                            input logic typed, input frame_result_t want);
    logic last;
    logic signed [31:0] junk;
    for (int i = 0; i < nbars; i++) begin
      last = (i == nbars - 1);
      junk = $urandom_range(1) ? -32'sd1 : 32'($urandom() >> 1);
      send_bar(6'($urandom_range(lo, hi)), last, last ? playing : 1'($urandom_range(1)),
               last ? pos : junk, typed, want);
      rand_items++;
    end
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending_frames.size() != 0);
  endtask

  task automatic check_field(input string what, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      errors++;
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    frame_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      frames_seen++;
      if (pending_frames.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, m_tdata);
        errors++;
      end else begin
        want = pending_frames.pop_front();
        check_field("frame_energy", want.energy, m_tdata[10:0]);
        check_field("average_energy", want.avg, m_tdata[29:11]);
        check_field("beat_pulse", want.pulse, m_tdata[45:30]);
        check_field("anim_phase", want.phase, m_tdata[77:46]);
        check_field("bars_counted", want.bars, m_tdata[83:78]);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // result side: random backpressure plus one long hold-off
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && frames_seen >= 15) begin
        held_off = 1'b1;
        m_tready <= 1'b0;
        repeat (300) @(negedge clk);
      end
      m_tready <= steady || ($urandom_range(99) >= 24);
    end
  end

  initial begin
    int k, nbars, mode, lo, hi, rand_frames;
    longint next;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    acc_energy = '0;
    acc_bars = '0;
    run_avg = 20'd256;
    beat_lvl = '0;
    phase = '0;
    last_pos = -32'sd1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_frames[i])
      send_frame(directed_frames[i].nbars, directed_frames[i].level,
                 directed_frames[i].level, directed_frames[i].playing,
                 directed_frames[i].pos, directed_frames[i].typed, directed_frames[i].want);
    drain_results();
    stim_pos = 210;

    rand_items = 0;
    rand_frames = 0;
    while (rand_items < 950 || rand_frames < 60) begin
      steady = (rand_items >= 300 && rand_items < 500);
      k = $urandom_range(99);
      if (k < 60) nbars = $urandom_range(1, 32);
      else if (k < 80) nbars = $urandom_range(33, 45);
      else nbars = $urandom_range(1, 4);
      mode = $urandom_range(2);
      lo = (mode == 1) ? 40 : 0;
      hi = (mode == 0) ? 7 : 63;
      k = $urandom_range(99);
      if (k < 75) begin
        next = (stim_pos < 0) ? longint'($urandom_range(0, 1000))
                              : stim_pos + $urandom_range(0, 250);
        if (next > POS_MAX) next = POS_MAX;
      end else if (k < 83) begin
        next = -1;
      end else if (k < 91) begin
        next = stim_pos - $urandom_range(1, 500);
        if (next < 0) next = 0;
      end else begin
        next = $urandom() >> 1;
      end
      stim_pos = next;
      send_frame(nbars, lo, hi, 1'($urandom_range(1)), 32'(next), 1'b0, '0);
      rand_frames++;
      if (rand_frames == 25) drain_results();
    end
    steady = 1'b0;

    drain_results();
    repeat (200) @(negedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
